FILE: hdl/sbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbe_pkg;

  localparam int unsigned StackDepthDef    = 64;
  localparam int unsigned VariableCountDef = 256;

  localparam int unsigned InWidth  = 80;
  localparam int unsigned OutWidth = 56;

  typedef enum logic [4:0] {
    OP_RESTART   = 5'd0,
    OP_CONST     = 5'd1,
    OP_TRUE      = 5'd2,
    OP_PUSH_ZERO = 5'd3,
    OP_ADD       = 5'd4,
    OP_SUB       = 5'd5,
    OP_MUL       = 5'd6,
    OP_DIV       = 5'd7,
    OP_MOD       = 5'd8,
    OP_EQ        = 5'd9,
    OP_LT        = 5'd10,
    OP_GT        = 5'd11,
    OP_LE        = 5'd12,
    OP_GE        = 5'd13,
    OP_SAVE      = 5'd14,
    OP_LOAD      = 5'd15,
    OP_EMIT      = 5'd16,
    OP_USER_IN   = 5'd17,
    OP_JUMP      = 5'd18,
    OP_JMPF      = 5'd19,
    OP_RET       = 5'd20
  } op_e;

  typedef enum logic [1:0] {
    CAUSE_RUN    = 2'd0,
    CAUSE_RETURN = 2'd1,
    CAUSE_END    = 2'd2,
    CAUSE_ERROR  = 2'd3
  } cause_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_UNDERFLOW = 3'd1,
    ERR_OVERFLOW  = 3'd2,
    ERR_UNDEF     = 3'd3,
    ERR_DIV_ZERO  = 3'd4,
    ERR_MOD_ZERO  = 3'd5,
    ERR_UNKNOWN   = 3'd6
  } err_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDB,
    S_RDA,
    S_EXEC,
    S_DIV,
    S_DFIN
  } state_e;

endpackage

`default_nettype wire

FILE: hdl/stack_bytecode_executor.sv
`timescale 1ns / 1ps
`default_nettype none
// Stack bytecode executor: runs one decoded stack-machine instruction per item.
// Input item (s_axis_*): operation, operand byte, fetched constant and user value.
// Result item (m_axis_*): output value and flag, next pointer, stop cause, error.
// Config channel (cfg_*): writes program_length; write only while the block is idle.
// One result item per input item, in order.
// An accepted item passes through S_RDB, S_RDA and S_EXEC, and its result is
// registered at S_EXEC; divide and modulo with a non-zero divisor go on through
// S_DIV and S_DFIN instead. The operand stack sits in a synchronous memory with
// one read port, so the two operands are fetched one after the other; S_DIV runs
// the 32-step restoring divider.
// One item is in flight at a time: the next item is taken once the previous one
// has reached the result register.
// A stalled receiver holds the result register; one further item is taken and
// waits at its final step, and input is refused after that.
// Reset empties the stack, clears the variable valid bits, the pointer, the
// halt flag and program_length; memories need no clearing pass. A restart
// instruction does the same for stack, valid bits, pointer and halt flag.
module stack_bytecode_executor
  import sbe_pkg::*;
#(
  parameter int unsigned STACK_DEPTH    = StackDepthDef,
  parameter int unsigned VARIABLE_COUNT = VariableCountDef
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  // operation[4:0], operand_byte[12:5], constant_value[44:13], user_value[76:45]
  input  wire [InWidth-1:0]    s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  // out_value[31:0], out_valid[32], next_pointer[48:33], stop_cause[50:49],
  // error_code[53:51]
  output logic [OutWidth-1:0]  m_axis_tdata,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire [15:0]           cfg_data_i
);

  localparam int unsigned SW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned VW = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;
  localparam logic [CW-1:0] DepthC = CW'(STACK_DEPTH);
  localparam logic [8:0]    VarCntC = 9'(VARIABLE_COUNT);

  state_e state_q, state_d;

  logic [15:0]   plen_q;
  logic [15:0]   ip_q, ip_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          halted_q, halted_d;

  // registered input item
  op_e         op_q;
  logic [7:0]  arg_q;
  logic [31:0] cval_q, uval_q;
  logic [31:0] b_q;

  // operand stack memory
  logic [31:0]   stk_mem [STACK_DEPTH];
  logic [31:0]   stk_rdata_q;
  logic [SW-1:0] stk_raddr, stk_waddr;
  logic          stk_we;
  logic [31:0]   stk_wdata;

  // variable store
  logic [31:0]            var_mem [VARIABLE_COUNT];
  logic [31:0]            var_rdata_q;
  logic [VARIABLE_COUNT-1:0] vld_q;
  logic                   var_we, vld_clr;

  // divider
  logic [32:0] dv_rem_q;
  logic [31:0] dv_quo_q, dv_den_q;
  logic [4:0]  dv_cnt_q;
  logic        dv_nq_q, dv_nr_q, dv_start;
  logic [32:0] dv_sh;

  // result register
  logic        m_valid_q;
  logic [31:0] r_val_q, r_val_d;
  logic        r_ok_q, r_ok_d;
  logic [15:0] r_ip_q;
  cause_e      r_cause_q, r_cause_d;
  err_e        r_err_q, r_err_d;
  logic        res_load;

  logic in_acc;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, r_err_q, r_cause_q, r_ip_q, r_ok_q, r_val_q};

  // stack read address: top first, then the entry below it
  always_comb begin
    if (state_q == S_RDB) begin
      stk_raddr = SW'(cnt_q - CW'(1));
    end else begin
      stk_raddr = SW'(cnt_q - CW'(2));
    end
  end

  // sequencer and execute
  always_comb begin
    logic [31:0] a, b, qv, rv;
    logic [15:0] nxt;
    logic        two, fin, pushing, hold;
    logic [31:0] pv;
    a        = stk_rdata_q;
    b        = b_q;
    two      = (op_q == OP_CONST) || (op_q == OP_SAVE) || (op_q == OP_LOAD) ||
               (op_q == OP_JUMP) || (op_q == OP_JMPF);
    nxt      = ip_q + (two ? 16'd2 : 16'd1);
    qv       = dv_nq_q ? (32'd0 - dv_quo_q) : dv_quo_q;
    rv       = dv_nr_q ? (32'd0 - dv_rem_q[31:0]) : dv_rem_q[31:0];
    fin      = 1'b0;
    pushing  = 1'b0;
    pv       = '0;
    state_d  = state_q;
    ip_d     = ip_q;
    cnt_d    = cnt_q;
    halted_d = halted_q;
    stk_we   = 1'b0;
    stk_waddr = SW'(cnt_q);
    stk_wdata = '0;
    var_we   = 1'b0;
    vld_clr  = 1'b0;
    dv_start = 1'b0;
    r_val_d  = '0;
    r_ok_d   = 1'b0;
    r_cause_d = CAUSE_RUN;
    r_err_d  = ERR_NONE;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_RDB;
      S_RDB:  state_d = S_RDA;
      S_RDA:  state_d = S_EXEC;
      S_EXEC: begin
        fin = 1'b1;
        if (op_q == OP_RESTART) begin
          ip_d     = '0;
          cnt_d    = '0;
          vld_clr  = 1'b1;
          halted_d = 1'b0;
        end else if (halted_q) begin
          r_cause_d = CAUSE_ERROR;
        end else if (ip_q >= plen_q) begin
          halted_d  = 1'b1;
          r_cause_d = CAUSE_END;
        end else begin
          ip_d = nxt;
          case (op_q)
            OP_CONST:     begin pushing = 1'b1; pv = cval_q; end
            OP_TRUE:      begin pushing = 1'b1; pv = 32'd1; end
            OP_PUSH_ZERO: begin pushing = 1'b1; pv = 32'd0; end
            OP_USER_IN:   begin pushing = 1'b1; pv = uval_q; end
            OP_LOAD: begin
              if ({1'b0, arg_q} >= VarCntC || !vld_q[arg_q[VW-1:0]]) begin
                r_err_d = ERR_UNDEF;
              end else begin
                pushing = 1'b1;
                pv = var_rdata_q;
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_LT, OP_GT, OP_LE,
            OP_GE: begin
              if (cnt_q < CW'(2)) begin
                r_err_d = ERR_UNDERFLOW;
              end else begin
                stk_waddr = SW'(cnt_q - CW'(2));
                cnt_d     = cnt_q - CW'(1);
                stk_we    = 1'b1;
                case (op_q)
                  OP_ADD: stk_wdata = a + b;
                  OP_SUB: stk_wdata = a - b;
                  OP_MUL: stk_wdata = a * b;
                  OP_EQ:  stk_wdata = {31'd0, a == b};
                  OP_LT:  stk_wdata = {31'd0, $signed(a) < $signed(b)};
                  OP_GT:  stk_wdata = {31'd0, $signed(a) > $signed(b)};
                  OP_LE:  stk_wdata = {31'd0, $signed(a) <= $signed(b)};
                  OP_GE:  stk_wdata = {31'd0, $signed(a) >= $signed(b)};
                  default: begin
                    stk_we = 1'b0;
                    cnt_d  = cnt_q;
                    if (b == '0) begin
                      r_err_d = (op_q == OP_DIV) ? ERR_DIV_ZERO : ERR_MOD_ZERO;
                    end else begin
                      ip_d     = ip_q;
                      dv_start = 1'b1;
                      fin      = 1'b0;
                      state_d  = S_DIV;
                    end
                  end
                endcase
              end
            end
            OP_SAVE: begin
              if (cnt_q == '0) begin
                r_err_d = ERR_UNDERFLOW;
              end else begin
                cnt_d  = cnt_q - CW'(1);
                var_we = ({1'b0, arg_q} < VarCntC);
              end
            end
            OP_EMIT: begin
              if (cnt_q == '0) begin
                r_err_d = ERR_UNDERFLOW;
              end else begin
                cnt_d   = cnt_q - CW'(1);
                r_val_d = b;
                r_ok_d  = 1'b1;
              end
            end
            OP_JUMP: ip_d = {8'd0, arg_q};
            OP_JMPF: begin
              if (cnt_q == '0) begin
                r_err_d = ERR_UNDERFLOW;
              end else begin
                cnt_d = cnt_q - CW'(1);
                if (b == '0) ip_d = {8'd0, arg_q};
              end
            end
            OP_RET: begin
              r_cause_d = CAUSE_RETURN;
              halted_d  = 1'b1;
            end
            default: r_err_d = ERR_UNKNOWN;
          endcase
          if (pushing) begin
            if (cnt_q >= DepthC) begin
              r_err_d = ERR_OVERFLOW;
            end else begin
              stk_we    = 1'b1;
              stk_wdata = pv;
              cnt_d     = cnt_q + CW'(1);
            end
          end
          if (r_err_d != ERR_NONE) begin
            halted_d  = 1'b1;
            r_cause_d = CAUSE_ERROR;
          end
        end
      end
      S_DIV: if (dv_cnt_q == 5'd31) state_d = S_DFIN;
      S_DFIN: begin
        fin       = 1'b1;
        ip_d      = nxt;
        stk_we    = 1'b1;
        stk_waddr = SW'(cnt_q - CW'(2));
        stk_wdata = (op_q == OP_DIV) ? qv : rv;
        cnt_d     = cnt_q - CW'(1);
      end
      default: state_d = S_IDLE;
    endcase
    // hold the final step while the previous result item is still waiting
    hold = fin && m_valid_q && !m_axis_tready;
    if (hold) begin
      state_d  = state_q;
      ip_d     = ip_q;
      cnt_d    = cnt_q;
      halted_d = halted_q;
      stk_we   = 1'b0;
      var_we   = 1'b0;
      vld_clr  = 1'b0;
      fin      = 1'b0;
    end
    // end of program check after the step
    if (fin) begin
      if (!halted_d && ip_d >= plen_q) begin
        halted_d  = 1'b1;
        r_cause_d = CAUSE_END;
      end
      state_d = S_IDLE;
    end
    res_load = fin;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      plen_q    <= '0;
      ip_q      <= '0;
      cnt_q     <= '0;
      halted_q  <= 1'b0;
      m_valid_q <= 1'b0;
      vld_q     <= '0;
    end else begin
      state_q  <= state_d;
      ip_q     <= ip_d;
      cnt_q    <= cnt_d;
      halted_q <= halted_d;
      if (cfg_valid_i) plen_q <= cfg_data_i;
      if (res_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (vld_clr) begin
        vld_q <= '0;
      end else if (var_we) begin
        vld_q[arg_q[VW-1:0]] <= 1'b1;
      end
    end
  end

  // item, operand and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_e'(s_axis_tdata[4:0]);
      arg_q  <= s_axis_tdata[12:5];
      cval_q <= s_axis_tdata[44:13];
      uval_q <= s_axis_tdata[76:45];
    end
    if (state_q == S_RDA) b_q <= stk_rdata_q;
    if (res_load) begin
      r_val_q   <= r_val_d;
      r_ok_q    <= r_ok_d;
      r_ip_q    <= ip_d;
      r_cause_q <= r_cause_d;
      r_err_q   <= r_err_d;
    end
  end

  // memories: write and registered read
  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_rdata_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (var_we) var_mem[arg_q[VW-1:0]] <= b_q;
    var_rdata_q <= var_mem[arg_q[VW-1:0]];
  end

  // restoring divider on magnitudes, one quotient bit a cycle
  assign dv_sh = {dv_rem_q[31:0], dv_quo_q[31]};
  always_ff @(posedge clk_i) begin
    if (dv_start) begin
      dv_rem_q <= '0;
      dv_quo_q <= stk_rdata_q[31] ? (32'd0 - stk_rdata_q) : stk_rdata_q;
      dv_den_q <= b_q[31] ? (32'd0 - b_q) : b_q;
      dv_nq_q  <= stk_rdata_q[31] ^ b_q[31];
      dv_nr_q  <= stk_rdata_q[31];
      dv_cnt_q <= '0;
    end else if (state_q == S_DIV) begin
      dv_cnt_q <= dv_cnt_q + 5'd1;
      if (dv_sh >= {1'b0, dv_den_q}) begin
        dv_rem_q <= dv_sh - {1'b0, dv_den_q};
        dv_quo_q <= {dv_quo_q[30:0], 1'b1};
      end else begin
        dv_rem_q <= dv_sh;
        dv_quo_q <= {dv_quo_q[30:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sbe_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sbe_checker
  import sbe_pkg::*;
(
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 s_axis_tvalid,
  input wire                 s_axis_tready,
  input wire [InWidth-1:0]   s_axis_tdata,
  input wire                 m_axis_tvalid,
  input wire                 m_axis_tready,
  input wire [OutWidth-1:0]  m_axis_tdata
);

  // hold a stalled result item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  // an error always halts with the error cause
  a_err_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[53:51] != ERR_NONE |-> m_axis_tdata[50:49] == CAUSE_ERROR)
    else $error("error code without error cause");

  // an output word comes only from an instruction that did not fail
  a_out_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[53:51] == ERR_NONE &&
    m_axis_tdata[50:49] != CAUSE_ERROR)
    else $error("output word flagged on a failed step");

  // a fresh result never appears in the cycle after an item is taken
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (!m_axis_tvalid || m_axis_tready) |=> !m_axis_tvalid)
    else $error("result too early");

endmodule

bind stack_bytecode_executor sbe_checker u_sbe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import sbe_pkg::*;

  localparam int Depth = 64;
  localparam int VarCount = 256;

  // one result item as the block reports it
  typedef struct packed {
    logic [2:0]  err;
    logic [1:0]  cause;
    logic [15:0] next_ptr;
    logic        out_ok;
    logic [31:0] out_val;
  } reply_t;

  // executor model plus queue of pending replies
  class exec_board;
    logic [31:0] stk [Depth];
    int          depth_cnt;
    logic [31:0] vars [VarCount];
    bit          vvalid [VarCount];
    logic [15:0] ip;
    bit          stopped;
    logic [15:0] prog_len;
    reply_t      pending [$];
    int          fails;

    function void clear_all();
      depth_cnt = 0; ip = 0; stopped = 0; prog_len = 0; fails = 0;
      foreach (vvalid[i]) vvalid[i] = 0;
    endfunction

    function automatic err_e push(logic [31:0] w);
      if (depth_cnt >= Depth) return ERR_OVERFLOW;
      stk[depth_cnt] = w;
      depth_cnt++;
      return ERR_NONE;
    endfunction

    function automatic logic [31:0] pop();
      depth_cnt--;
      return stk[depth_cnt];
    endfunction

    // execute one instruction and queue its reply
    function void note_instr(op_e op, logic [7:0] arg, logic [31:0] cv, logic [31:0] uv);
      reply_t r;
      err_e e;
      logic signed [31:0] a, b;
      logic [15:0] nxt;
      bit two;
      r = '0; e = ERR_NONE; a = 0; b = 0;
      if (op == OP_RESTART) begin
        ip = 0; depth_cnt = 0; stopped = 0;
        foreach (vvalid[i]) vvalid[i] = 0;
      end else if (stopped) begin
        r.cause = CAUSE_ERROR;
      end else if (ip >= prog_len) begin
        stopped = 1; r.cause = CAUSE_END;
      end else begin
        two = op inside {OP_CONST, OP_SAVE, OP_LOAD, OP_JUMP, OP_JMPF};
        nxt = ip + (two ? 16'd2 : 16'd1);
        if (op >= OP_ADD && op <= OP_GE) begin
          if (depth_cnt < 2) e = ERR_UNDERFLOW;
          else begin b = pop(); a = pop(); end
        end
        if (e == ERR_NONE) begin
          case (op)
            OP_CONST:     e = push(cv);
            OP_TRUE:      e = push(1);
            OP_PUSH_ZERO: e = push(0);
            OP_ADD:       e = push(a + b);
            OP_SUB:       e = push(a - b);
            OP_MUL:       e = push(a * b);
            OP_DIV: begin
              if (b == 0) e = ERR_DIV_ZERO;
              else if (a == 32'sh80000000 && b == -1) e = push(a);
              else e = push(a / b);
            end
            OP_MOD: begin
              if (b == 0) e = ERR_MOD_ZERO;
              else if (b == -1) e = push(0);
              else e = push(a % b);
            end
            OP_EQ: e = push(a == b);
            OP_LT: e = push(a < b);
            OP_GT: e = push(a > b);
            OP_LE: e = push(a <= b);
            OP_GE: e = push(a >= b);
            OP_SAVE: begin
              if (depth_cnt == 0) e = ERR_UNDERFLOW;
              else begin vars[arg] = pop(); vvalid[arg] = 1; end
            end
            OP_LOAD: begin
              if (!vvalid[arg]) e = ERR_UNDEF;
              else e = push(vars[arg]);
            end
            OP_EMIT: begin
              if (depth_cnt == 0) e = ERR_UNDERFLOW;
              else begin r.out_val = pop(); r.out_ok = 1; end
            end
            OP_USER_IN: e = push(uv);
            OP_JUMP: nxt = arg;
            OP_JMPF: begin
              if (depth_cnt == 0) e = ERR_UNDERFLOW;
              else if (pop() == 0) nxt = arg;
            end
            OP_RET: begin r.cause = CAUSE_RETURN; stopped = 1; end
            default: e = ERR_UNKNOWN;
          endcase
        end
        ip = nxt;
        if (e != ERR_NONE) begin stopped = 1; r.cause = CAUSE_ERROR; end
      end
      if (!stopped && ip >= prog_len) begin stopped = 1; r.cause = CAUSE_END; end
      r.next_ptr = ip;
      r.err = e;
      pending = {pending, r};
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        fails++;
        return;
      end
      want = pending.pop_front();
      if (got.out_val !== want.out_val || got.out_ok !== want.out_ok) begin
        $display("%0t: out value exp %h/%b got %h/%b", $time, want.out_val, want.out_ok,
                 got.out_val, got.out_ok);
        fails++;
      end
      if (got.next_ptr !== want.next_ptr) begin
        $display("%0t: next pointer exp %h got %h", $time, want.next_ptr, got.next_ptr);
        fails++;
      end
      if (got.cause !== want.cause || got.err !== want.err) begin
        $display("%0t: cause/error exp %0d/%0d got %0d/%0d", $time, want.cause, want.err,
                 got.cause, got.err);
        fails++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  wire         s_axis_tready;
  logic [InWidth-1:0] s_axis_tdata = '0;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 0;
  wire [OutWidth-1:0] m_axis_tdata;
  logic        cfg_valid_i = 0;
  wire         cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  exec_board board;
  bit        hold_off = 0;

  stack_bytecode_executor uut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always #2 clk_i = ~clk_i;

  // offer one instruction, note it on acceptance
  task automatic send_instr(op_e op, logic [7:0] arg, logic [31:0] cv, logic [31:0] uv);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata = '0;
    s_axis_tdata[76:0] = {uv, cv, arg, op};
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_instr(op, arg, cv, uv);
    @(negedge clk_i);
  endtask

  // write program_length once idle
  task automatic write_len(logic [15:0] len);
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    cfg_data_i <= len;
    cfg_valid_i <= 1;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.prog_len = len;
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'hffffffff;
      3: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // receiver: random wait per item, plus one long hold-off on request
  initial begin
    int w;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        hold_off = 0;
        m_axis_tready <= 0;
        repeat (300) @(negedge clk_i);
      end
      w = $urandom_range(0, 7);
      if (w != 0) begin
        m_axis_tready <= 0;
        repeat (w) @(negedge clk_i);
      end
      m_axis_tready <= 1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_reply(m_axis_tdata[53:0]);

  initial begin
    #20000000;
    $display("FAIL stack_bytecode_executor");
    $finish;
  end

  initial begin
    op_e op;
    board = new();
    board.clear_all();
    repeat (8) @(negedge clk_i);
    rst_ni = 1;

    // directed: end of program with zero length, then a real program
    send_instr(OP_CONST, 0, 1, 0);
    send_instr(OP_RESTART, 0, 0, 0);
    write_len(16'hffff);
    send_instr(OP_RESTART, 0, 0, 0);
    send_instr(OP_CONST, 8'hff, 32'h80000000, 0);
    send_instr(OP_USER_IN, 0, 0, 32'hffffffff);
    send_instr(OP_DIV, 0, 0, 0);
    send_instr(OP_USER_IN, 0, 0, 32'hffffffff);
    send_instr(OP_MOD, 0, 0, 0);
    send_instr(OP_SAVE, 8'hff, 0, 0);
    send_instr(OP_LOAD, 8'hff, 0, 0);
    send_instr(OP_TRUE, 0, 0, 0);
    for (int k = OP_ADD; k <= OP_GE; k++) begin
      send_instr(OP_CONST, 0, rand_word(), 0);
      send_instr(op_e'(k), 0, 0, 0);
    end
    send_instr(OP_PUSH_ZERO, 0, 0, 0);
    send_instr(OP_JMPF, 8'h10, 0, 0);
    send_instr(OP_EMIT, 0, 0, 0);
    send_instr(OP_EMIT, 0, 0, 0);
    send_instr(OP_EMIT, 0, 0, 0);
    send_instr(OP_RESTART, 0, 0, 0);
    send_instr(OP_LOAD, 3, 0, 0);
    send_instr(OP_RESTART, 0, 0, 0);
    send_instr(OP_CONST, 0, 0, 0);
    send_instr(OP_DIV, 0, 0, 0);
    send_instr(OP_RESTART, 0, 0, 0);
    for (int k = 0; k < 65; k++) send_instr(OP_TRUE, 0, 0, 0);
    send_instr(op_e'(5'd31), 0, 0, 0);
    send_instr(OP_RESTART, 0, 0, 0);
    send_instr(op_e'(5'd21), 0, 0, 0);
    send_instr(OP_RESTART, 0, 0, 0);
    send_instr(OP_JUMP, 8'h00, 0, 0);
    send_instr(OP_RET, 0, 0, 0);

    // random programs over several lengths
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_len(16'd1);
        1: write_len(16'd40);
        2: write_len(16'd200);
        3: write_len(16'd0);
        default: write_len(16'hffff);
      endcase
      for (int k = 0; k < 147; k++) begin
        if (ph == 2 && k == 50) hold_off = 1;
        if ($urandom_range(0, 24) == 0) op = OP_RESTART;
        else if ($urandom_range(0, 29) == 0) op = op_e'($urandom_range(21, 31));
        else if ($urandom_range(0, 2) == 0)
          op = ($urandom_range(0, 1) != 0) ? OP_CONST : OP_USER_IN;
        else op = op_e'($urandom_range(1, 20));
        if (op == OP_RET && $urandom_range(0, 3) != 0) op = OP_EMIT;
        send_instr(op, ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)),
                   rand_word(), rand_word());
      end
    end

    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (board.fails == 0) $display("PASS stack_bytecode_executor");
    else $display("FAIL stack_bytecode_executor");
    $finish;
  end
endmodule

FILE: stack_bytecode_executor.f
hdl/sbe_pkg.sv
hdl/stack_bytecode_executor.sv
hdl/sbe_checker.sv
tb/tb.sv
